// ----- rtl/core/gae_pkg.sv -----
// Shared types, command codes and the arithmetic sequence for the airspeed estimator.
package gae_pkg;

   typedef struct packed {
      logic        mode;
      logic [15:0] quat_w;
      logic [15:0] quat_x;
      logic [15:0] quat_y;
      logic [15:0] quat_z;
      logic [15:0] vel_north;
      logic [15:0] vel_east;
      logic [15:0] vel_down;
   } req_type;

   typedef struct packed {
      logic        updated;
      logic [15:0] airspeed_cms;
      logic        estimate_valid;
      logic        alarm_level;
   } rsp_type;

   typedef struct packed {
      logic [16:0] filter_alpha;
      logic [14:0] turn_cosine_limit;
      logic [31:0] min_speed_squared;
   } cfg_type;

   localparam logic [16:0] ALPHA_RESET = 17'd6554;
   localparam logic [14:0] LIMIT_RESET = 15'd16322;
   localparam logic [31:0] MINSPD_RESET = 32'd10000;
   localparam logic [16:0] ONE_Q16 = 17'd65536;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_ALPHA = 2'd0;
   localparam logic [1:0] REG_LIMIT = 2'd1;
   localparam logic [1:0] REG_MINSPD = 2'd2;

   // Multiplier operand pairs.
   localparam logic [4:0] M_WW = 5'd0;
   localparam logic [4:0] M_XX = 5'd1;
   localparam logic [4:0] M_YY = 5'd2;
   localparam logic [4:0] M_ZZ = 5'd3;
   localparam logic [4:0] M_XY = 5'd4;
   localparam logic [4:0] M_WZ = 5'd5;
   localparam logic [4:0] M_XZ = 5'd6;
   localparam logic [4:0] M_WY = 5'd7;
   localparam logic [4:0] M_F0R = 5'd8;
   localparam logic [4:0] M_F1R = 5'd9;
   localparam logic [4:0] M_F2R = 5'd10;
   localparam logic [4:0] M_VN = 5'd11;
   localparam logic [4:0] M_VE = 5'd12;
   localparam logic [4:0] M_VD = 5'd13;
   localparam logic [4:0] M_DV0 = 5'd14;
   localparam logic [4:0] M_DV1 = 5'd15;
   localparam logic [4:0] M_DV2 = 5'd16;
   localparam logic [4:0] M_DF0 = 5'd17;
   localparam logic [4:0] M_DF1 = 5'd18;
   localparam logic [4:0] M_DF2 = 5'd19;
   localparam logic [4:0] M_AR = 5'd20;
   localparam logic [4:0] M_BF = 5'd21;
   localparam logic [4:0] M_IDLE = 5'd31;

   // Accumulator actions on the product of the previous cycle.
   localparam logic [1:0] A_NONE = 2'd0;
   localparam logic [1:0] A_LOAD = 2'd1;
   localparam logic [1:0] A_ADD = 2'd2;
   localparam logic [1:0] A_SUB = 2'd3;

   // Destinations of the accumulator value.
   localparam logic [3:0] ST_NONE = 4'd0;
   localparam logic [3:0] ST_FUS0 = 4'd1;
   localparam logic [3:0] ST_FUS1 = 4'd2;
   localparam logic [3:0] ST_FUS2 = 4'd3;
   localparam logic [3:0] ST_DOT = 4'd4;
   localparam logic [3:0] ST_SPD = 4'd5;
   localparam logic [3:0] ST_DVS = 4'd6;
   localparam logic [3:0] ST_DFS = 4'd7;
   localparam logic [3:0] ST_FILT = 4'd8;

   // Sequencing operations.
   localparam logic [3:0] SQ_NONE = 4'd0;
   localparam logic [3:0] SQ_CAPTURE = 4'd1;
   localparam logic [3:0] SQ_DIV_INIT = 4'd2;
   localparam logic [3:0] SQ_DIV_STEP = 4'd3;
   localparam logic [3:0] SQ_SQRT_INIT = 4'd4;
   localparam logic [3:0] SQ_SQRT_STEP = 4'd5;
   localparam logic [3:0] SQ_CM_LOAD = 4'd6;
   localparam logic [3:0] SQ_CM_NOTURN = 4'd7;
   localparam logic [3:0] SQ_CM_SLOW = 4'd8;
   localparam logic [3:0] SQ_CM_ZERO = 4'd9;
   localparam logic [3:0] SQ_CM_GOOD = 4'd10;

   typedef struct packed {
      logic [4:0] mul_sel;
      logic [1:0] acc_op;
      logic [3:0] store_sel;
      logic [3:0] seq_op;
   } cmd_type;

   typedef struct packed {
      logic mode;
      logic turn_ok;
      logic slow;
      logic df_zero;
   } sts_type;

   localparam logic [4:0] LAST_MAIN_STEP = 5'd22;
   localparam logic [4:0] FIRST_FILT_STEP = 5'd23;
   localparam logic [4:0] LAST_FILT_STEP = 5'd26;
   localparam logic [4:0] LAST_ITER = 5'd30;

   // Multiply-accumulate program. The accumulator acts on the product of the step before.
   function automatic cmd_type ucode(input logic [4:0] step);
      cmd_type c;
      c = '{mul_sel: M_IDLE, acc_op: A_NONE, store_sel: ST_NONE, seq_op: SQ_NONE};
      case (step)
         5'd0: c.mul_sel = M_WW;
         5'd1: begin c.mul_sel = M_XX; c.acc_op = A_LOAD; end
         5'd2: begin c.mul_sel = M_YY; c.acc_op = A_ADD; end
         5'd3: begin c.mul_sel = M_ZZ; c.acc_op = A_SUB; end
         5'd4: begin c.mul_sel = M_XY; c.acc_op = A_SUB; end
         5'd5: begin c.mul_sel = M_WZ; c.acc_op = A_LOAD; c.store_sel = ST_FUS0; end
         5'd6: begin c.mul_sel = M_XZ; c.acc_op = A_ADD; end
         5'd7: begin c.mul_sel = M_WY; c.acc_op = A_LOAD; c.store_sel = ST_FUS1; end
         5'd8: c.acc_op = A_SUB;
         5'd9: begin c.mul_sel = M_F0R; c.store_sel = ST_FUS2; end
         5'd10: begin c.mul_sel = M_F1R; c.acc_op = A_LOAD; end
         5'd11: begin c.mul_sel = M_F2R; c.acc_op = A_ADD; end
         5'd12: begin c.mul_sel = M_VN; c.acc_op = A_ADD; end
         5'd13: begin c.mul_sel = M_VE; c.acc_op = A_LOAD; c.store_sel = ST_DOT; end
         5'd14: begin c.mul_sel = M_VD; c.acc_op = A_ADD; end
         5'd15: begin c.mul_sel = M_DV0; c.acc_op = A_ADD; end
         5'd16: begin c.mul_sel = M_DV1; c.acc_op = A_LOAD; c.store_sel = ST_SPD; end
         5'd17: begin c.mul_sel = M_DV2; c.acc_op = A_ADD; end
         5'd18: begin c.mul_sel = M_DF0; c.acc_op = A_ADD; end
         5'd19: begin c.mul_sel = M_DF1; c.acc_op = A_LOAD; c.store_sel = ST_DVS; end
         5'd20: begin c.mul_sel = M_DF2; c.acc_op = A_ADD; end
         5'd21: c.acc_op = A_ADD;
         5'd22: c.store_sel = ST_DFS;
         5'd23: c.mul_sel = M_AR;
         5'd24: begin c.mul_sel = M_BF; c.acc_op = A_LOAD; end
         5'd25: c.acc_op = A_ADD;
         5'd26: c.store_sel = ST_FILT;
         default: c.mul_sel = M_IDLE;
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/core/gae_csr.sv -----
// Configuration registers behind the APB-style port.
module gae_csr
   import gae_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[3:2])
            REG_ALPHA: cfg_in.filter_alpha = csr_pwdata[16:0];
            REG_LIMIT: cfg_in.turn_cosine_limit = csr_pwdata[14:0];
            REG_MINSPD: cfg_in.min_speed_squared = csr_pwdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_ALPHA: csr_prdata = {15'd0, cfg_ff.filter_alpha};
         REG_LIMIT: csr_prdata = {17'd0, cfg_ff.turn_cosine_limit};
         REG_MINSPD: csr_prdata = cfg_ff.min_speed_squared;
         default: csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{filter_alpha: ALPHA_RESET, turn_cosine_limit: LIMIT_RESET,
                     min_speed_squared: MINSPD_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/core/gae_ctrl.sv -----
// Controller state machine that sequences the estimator datapath.
module gae_ctrl
   import gae_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RUN = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_DIV = 3'd3;
   localparam logic [2:0] S_SQI = 3'd4;
   localparam logic [2:0] S_SQRT = 3'd5;
   localparam logic [2:0] S_FILT = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       good;
   logic       out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign good = sts.mode && sts.turn_ok && !sts.slow && !sts.df_zero;
   assign out_free = !(rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd = ucode(cnt_ff);
      case (state_ff)
         S_IDLE: begin
            cmd = '{mul_sel: M_IDLE, acc_op: A_NONE, store_sel: ST_NONE, seq_op: SQ_NONE};
            if (req_valid) begin
               cmd.seq_op = SQ_CAPTURE;
               cnt_in = 5'd0;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == LAST_MAIN_STEP) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd = '{mul_sel: M_IDLE, acc_op: A_NONE, store_sel: ST_NONE, seq_op: SQ_NONE};
            cnt_in = 5'd0;
            if (good) begin
               cmd.seq_op = SQ_DIV_INIT;
               state_in = S_DIV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            cmd = '{mul_sel: M_IDLE, acc_op: A_NONE, store_sel: ST_NONE, seq_op: SQ_DIV_STEP};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == LAST_ITER) begin
               state_in = S_SQI;
            end
         end
         S_SQI: begin
            cmd = '{mul_sel: M_IDLE, acc_op: A_NONE, store_sel: ST_NONE,
                    seq_op: SQ_SQRT_INIT};
            cnt_in = 5'd0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd = '{mul_sel: M_IDLE, acc_op: A_NONE, store_sel: ST_NONE,
                    seq_op: SQ_SQRT_STEP};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == LAST_ITER) begin
               cnt_in = FIRST_FILT_STEP;
               state_in = S_FILT;
            end
         end
         S_FILT: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == LAST_FILT_STEP) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd = '{mul_sel: M_IDLE, acc_op: A_NONE, store_sel: ST_NONE, seq_op: SQ_NONE};
            if (out_free) begin
               if (!sts.mode) begin
                  cmd.seq_op = SQ_CM_LOAD;
               end else if (!sts.turn_ok) begin
                  cmd.seq_op = SQ_CM_NOTURN;
               end else if (sts.slow) begin
                  cmd.seq_op = SQ_CM_SLOW;
               end else if (sts.df_zero) begin
                  cmd.seq_op = SQ_CM_ZERO;
               end else begin
                  cmd.seq_op = SQ_CM_GOOD;
               end
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/core/gae_datapath.sv -----
// Datapath: shared multiplier and accumulator, radix-4 divider, square root and state.
module gae_datapath
   import gae_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cfg_type cfg,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_data
);

   req_type            item_ff;
   logic signed [15:0] fus_ff [3];
   logic signed [15:0] ref_fus_ff [3];
   logic signed [15:0] ref_vel_ff [3];
   logic [15:0]        filt_ff;
   logic signed [35:0] prod_ff;
   logic signed [39:0] acc_ff, acc_in;
   logic [33:0]        dv2_ff;
   logic [33:0]        df2_ff;
   logic               turn_ok_ff, slow_ff, df_zero_ff;
   logic [61:0]        nq_ff, nq_in;
   logic [33:0]        rem_ff, rem_in;
   logic [61:0]        sx_ff, sx_in;
   logic [61:0]        sres_ff, sres_in;
   logic [61:0]        sbit_ff, sbit_in;
   rsp_type            rsp_ff;

   logic signed [15:0] vel [3];
   logic signed [17:0] op_a, op_b;
   logic signed [17:0] dv [3];
   logic signed [17:0] df [3];
   logic [16:0]        alpha_eff;
   logic [15:0]        raw;
   logic [15:0]        fus_round;
   logic [15:0]        filt_new;
   logic               turn_ok_new;
   logic               slow_new;

   assign vel[0] = item_ff.vel_north;
   assign vel[1] = item_ff.vel_east;
   assign vel[2] = item_ff.vel_down;
   assign alpha_eff = (cfg.filter_alpha > ONE_Q16) ? ONE_Q16 : cfg.filter_alpha;
   assign raw = (sres_ff > 62'd65535) ? 16'hFFFF : sres_ff[15:0];
   assign sts = '{mode: item_ff.mode, turn_ok: turn_ok_ff, slow: slow_ff, df_zero: df_zero_ff};
   assign rsp_data = rsp_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dv[i] = 18'(vel[i]) - 18'(ref_vel_ff[i]);
         df[i] = 18'(fus_ff[i]) - 18'(ref_fus_ff[i]);
      end
   end

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (cmd.mul_sel)
         M_WW: begin op_a = 18'(signed'(item_ff.quat_w)); op_b = op_a; end
         M_XX: begin op_a = 18'(signed'(item_ff.quat_x)); op_b = op_a; end
         M_YY: begin op_a = 18'(signed'(item_ff.quat_y)); op_b = op_a; end
         M_ZZ: begin op_a = 18'(signed'(item_ff.quat_z)); op_b = op_a; end
         M_XY: begin
            op_a = 18'(signed'(item_ff.quat_x));
            op_b = 18'(signed'(item_ff.quat_y));
         end
         M_WZ: begin
            op_a = 18'(signed'(item_ff.quat_w));
            op_b = 18'(signed'(item_ff.quat_z));
         end
         M_XZ: begin
            op_a = 18'(signed'(item_ff.quat_x));
            op_b = 18'(signed'(item_ff.quat_z));
         end
         M_WY: begin
            op_a = 18'(signed'(item_ff.quat_w));
            op_b = 18'(signed'(item_ff.quat_y));
         end
         M_F0R: begin op_a = 18'(fus_ff[0]); op_b = 18'(ref_fus_ff[0]); end
         M_F1R: begin op_a = 18'(fus_ff[1]); op_b = 18'(ref_fus_ff[1]); end
         M_F2R: begin op_a = 18'(fus_ff[2]); op_b = 18'(ref_fus_ff[2]); end
         M_VN: begin op_a = 18'(vel[0]); op_b = op_a; end
         M_VE: begin op_a = 18'(vel[1]); op_b = op_a; end
         M_VD: begin op_a = 18'(vel[2]); op_b = op_a; end
         M_DV0: begin op_a = dv[0]; op_b = dv[0]; end
         M_DV1: begin op_a = dv[1]; op_b = dv[1]; end
         M_DV2: begin op_a = dv[2]; op_b = dv[2]; end
         M_DF0: begin op_a = df[0]; op_b = df[0]; end
         M_DF1: begin op_a = df[1]; op_b = df[1]; end
         M_DF2: begin op_a = df[2]; op_b = df[2]; end
         M_AR: begin
            op_a = signed'({1'b0, alpha_eff});
            op_b = signed'({2'b00, raw});
         end
         M_BF: begin
            op_a = signed'({1'b0, ONE_Q16 - alpha_eff});
            op_b = signed'({2'b00, filt_ff});
         end
         default: op_a = '0;
      endcase
   end

   always_comb begin
      case (cmd.acc_op)
         A_LOAD: acc_in = 40'(prod_ff);
         A_ADD: acc_in = acc_ff + 40'(prod_ff);
         A_SUB: acc_in = acc_ff - 40'(prod_ff);
         default: acc_in = acc_ff;
      endcase
   end

   // Q2.28 to Q1.14 with round half up and saturation; the cross terms count double.
   always_comb begin
      logic signed [41:0] v;
      logic signed [41:0] r;
      v = (cmd.store_sel == ST_FUS0) ? 42'(acc_ff) : (42'(acc_ff) <<< 1);
      r = (v + 42'sd8192) >>> 14;
      if (r > 42'sd32767) begin
         fus_round = 16'h7FFF;
      end else if (r < -42'sd32768) begin
         fus_round = 16'h8000;
      end else begin
         fus_round = r[15:0];
      end
   end

   always_comb begin
      logic [39:0] mag;
      mag = acc_ff[39] ? 40'(-acc_ff) : 40'(acc_ff);
      turn_ok_new = mag < {11'd0, cfg.turn_cosine_limit, 14'd0};
      slow_new = 40'(acc_ff) < {8'd0, cfg.min_speed_squared};
   end

   always_comb begin
      logic [39:0] s;
      s = 40'(acc_ff) + 40'd32768;
      filt_new = s[31:16];
   end

   // Two restoring division steps per cycle.
   always_comb begin
      logic [34:0] r1, r2;
      logic        g1, g2;
      r1 = {rem_ff, nq_ff[61]};
      g1 = r1 >= {1'b0, df2_ff};
      if (g1) r1 = r1 - {1'b0, df2_ff};
      r2 = {r1[33:0], nq_ff[60]};
      g2 = r2 >= {1'b0, df2_ff};
      if (g2) r2 = r2 - {1'b0, df2_ff};
      nq_in = {nq_ff[59:0], g1, g2};
      rem_in = r2[33:0];
   end

   always_comb begin
      logic [61:0] t;
      t = sres_ff + sbit_ff;
      sx_in = sx_ff;
      if (sx_ff >= t) begin
         sx_in = sx_ff - t;
         sres_in = (sres_ff >> 1) + sbit_ff;
      end else begin
         sres_in = sres_ff >> 1;
      end
      sbit_in = sbit_ff >> 2;
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      acc_ff <= acc_in;
      if (cmd.seq_op == SQ_CAPTURE) begin
         item_ff <= req_data;
      end
      case (cmd.store_sel)
         ST_FUS0: fus_ff[0] <= fus_round;
         ST_FUS1: fus_ff[1] <= fus_round;
         ST_FUS2: fus_ff[2] <= fus_round;
         ST_DVS: dv2_ff <= acc_ff[33:0];
         ST_DFS: df2_ff <= acc_ff[33:0];
         default: dv2_ff <= dv2_ff;
      endcase
      case (cmd.seq_op)
         SQ_DIV_INIT: begin
            nq_ff <= {dv2_ff, 28'd0};
            rem_ff <= '0;
         end
         SQ_DIV_STEP: begin
            nq_ff <= nq_in;
            rem_ff <= rem_in;
         end
         SQ_SQRT_INIT: begin
            sx_ff <= nq_ff;
            sres_ff <= '0;
            sbit_ff <= 62'd1 << 60;
         end
         SQ_SQRT_STEP: begin
            sx_ff <= sx_in;
            sres_ff <= sres_in;
            sbit_ff <= sbit_in;
         end
         SQ_CM_LOAD, SQ_CM_NOTURN: rsp_ff <= '0;
         SQ_CM_SLOW, SQ_CM_ZERO: rsp_ff <= '{updated: 1'b1, airspeed_cms: 16'd0,
                                            estimate_valid: 1'b0, alarm_level: 1'b1};
         SQ_CM_GOOD: rsp_ff <= '{updated: 1'b1, airspeed_cms: filt_ff,
                                 estimate_valid: 1'b1, alarm_level: 1'b0};
         default: rsp_ff <= rsp_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            ref_fus_ff[i] <= '0;
            ref_vel_ff[i] <= '0;
         end
         filt_ff <= '0;
         turn_ok_ff <= 1'b0;
         slow_ff <= 1'b0;
         df_zero_ff <= 1'b0;
      end else begin
         if (cmd.store_sel == ST_DOT) turn_ok_ff <= turn_ok_new;
         if (cmd.store_sel == ST_SPD) slow_ff <= slow_new;
         if (cmd.store_sel == ST_DFS) df_zero_ff <= (acc_ff == 40'sd0);
         if (cmd.store_sel == ST_FILT) filt_ff <= filt_new;
         if (cmd.seq_op == SQ_CM_LOAD) filt_ff <= '0;
         if (cmd.seq_op == SQ_CM_LOAD || cmd.seq_op == SQ_CM_ZERO ||
             cmd.seq_op == SQ_CM_GOOD) begin
            for (int i = 0; i < 3; i++) begin
               ref_fus_ff[i] <= fus_ff[i];
               ref_vel_ff[i] <= vel[i];
            end
         end
      end
   end

endmodule

// ----- rtl/core/gps_airspeed_estimator.sv -----
// Top level of the GPS wind-triangle airspeed estimator.
//
// Requests carry an attitude quaternion, a NED ground velocity and a mode bit on
// req_data under req_valid / req_stall; each request yields exactly one response
// on rsp_data under rsp_valid / rsp_stall. Mode 0 loads the reference attitude and
// velocity and clears the filter; mode 1 attempts an airspeed update.
// One request is worked at a time; req_stall is high while it is in flight.
// The shared multiply-accumulate program runs first and one more state picks
// the case, so a request that ends without an estimate (load, too little turn,
// slow, zero divisor) then raises rsp_valid. A full update adds radix-4
// division, square root and filtering before the response. The next request
// can be accepted in the same cycle as the response is issued.
// The response sits in an output register; a stalled response holds its value and
// the next request is still accepted, but its response waits until the first is
// taken. Reset clears the references, the filter and the registers to defaults.
// Registers: filter_alpha at 0x0, turn_cosine_limit at 0x4, min_speed_squared at
// 0x8; write them only while no request is in flight.
module gps_airspeed_estimator
   import gae_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   gae_csr u_csr (
      .clock(clock), .reset(reset),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready), .cfg(cfg)
   );

   gae_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .sts(sts), .cmd(cmd)
   );

   gae_datapath u_dp (
      .clock(clock), .reset(reset),
      .req_data(req_data), .cfg(cfg), .cmd(cmd),
      .sts(sts), .rsp_data(rsp_data)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while not busy afterwards");

   a_valid_not_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.estimate_valid && rsp_data.alarm_level))
      else $error("response both valid and in alarm");

   a_not_updated_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.updated |->
         rsp_data.airspeed_cms == 16'd0 && !rsp_data.estimate_valid && !rsp_data.alarm_level)
      else $error("response without update carries data");

endmodule
